/* rtl/orse_pkg.sv */
// Package for the on-off-keyed remote switch encoder.
// Holds the configuration record, register indexes, reset constants and frame helpers.
// No dependencies.
package orse_pkg;

  localparam int unsigned TimerBitsDefault = 16;
  localparam int unsigned Symbols          = 12;

  localparam logic [11:0] ShortPulseRst  = 12'd320;
  localparam logic [11:0] LongPulseRst   = 12'd900;
  localparam logic [15:0] SyncGapRst     = 16'd10000;
  localparam logic [3:0]  RepeatCountRst = 4'd6;

  typedef enum logic [1:0] {
    REG_SHORT_PULSE  = 2'd0,
    REG_LONG_PULSE   = 2'd1,
    REG_SYNC_GAP     = 2'd2,
    REG_REPEAT_COUNT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] short_pulse_us;
    logic [11:0] long_pulse_us;
    logic [15:0] sync_gap_us;
    logic [3:0]  repeat_count;
  } cfg_t;

  typedef struct packed {
    logic line_high;
    logic busy_res;
    logic done_res;
    logic rejected;
  } res_t;

  typedef struct packed {
    logic        level;
    logic [15:0] len;
  } seg_t;

  // Symbol bit set means F: house bits 3..7, switch positions 1..5, then power pair.
  function automatic logic [11:0] build_pattern(input logic [7:0] house,
                                                input logic [3:0] sw,
                                                input logic       pwr);
    logic [11:0] pat;
    pat        = '0;
    pat[4:0]   = house[7:3];
    pat[5]     = (sw != 4'd1);
    pat[6]     = (sw != 4'd2);
    pat[7]     = (sw != 4'd3);
    pat[8]     = (sw != 4'd4);
    pat[9]     = (sw != 4'd5);
    pat[10]    = ~pwr;
    pat[11]    = pwr;
    return pat;
  endfunction

  // Level and raw length of the segment at a given position.
  function automatic seg_t load_seg(input logic        sync,
                                    input logic [1:0]  seg,
                                    input logic [3:0]  sym,
                                    input logic [11:0] pat,
                                    input cfg_t        cfg);
    seg_t r;
    logic is_f;
    is_f = (sym < 4'd12) && (|(pat & (12'd1 << sym)));
    if (sync) begin
      if (seg == 2'd0) begin
        r.level = 1'b1;
        r.len   = {4'd0, cfg.short_pulse_us};
      end else begin
        r.level = 1'b0;
        r.len   = cfg.sync_gap_us;
      end
    end else begin
      case (seg)
        2'd0: begin
          r.level = 1'b1;
          r.len   = {4'd0, cfg.short_pulse_us};
        end
        2'd1: begin
          r.level = 1'b0;
          r.len   = {4'd0, cfg.long_pulse_us};
        end
        2'd2: begin
          r.level = 1'b1;
          r.len   = {4'd0, is_f ? cfg.long_pulse_us : cfg.short_pulse_us};
        end
        default: begin
          r.level = 1'b0;
          r.len   = {4'd0, is_f ? cfg.short_pulse_us : cfg.long_pulse_us};
        end
      endcase
    end
    return r;
  endfunction

endpackage

/* rtl/orse_seq.sv */
// Segment sequencer: frame position, segment timer and per-transaction result.
// Depends on orse_pkg.
module orse_seq #(
  parameter int unsigned TIMER_BITS = orse_pkg::TimerBitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              req_type,
  input  logic [7:0]        house_code,
  input  logic [3:0]        switch_number,
  input  logic              power_on,
  input  orse_pkg::cfg_t    cfg,
  output orse_pkg::res_t    res
);
  import orse_pkg::*;

  localparam int unsigned LenBits = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic                  active_r,  active_nxt;
  logic [3:0]            frame_r,   frame_nxt;
  logic [3:0]            sym_r,     sym_nxt;
  logic [1:0]            seg_r,     seg_nxt;
  logic                  sync_r,    sync_nxt;
  logic [TIMER_BITS-1:0] tl_r,      tl_nxt;
  logic [11:0]           pat_r,     pat_nxt;
  logic                  level_r,   level_nxt;

  // Zero becomes one tick; lengths beyond the timer saturate.
  function automatic logic [TIMER_BITS-1:0] clamp_len(input logic [15:0] len);
    logic [LenBits-1:0] ext;
    logic [LenBits-1:0] tmax;
    ext  = LenBits'(len);
    tmax = LenBits'({TIMER_BITS{1'b1}});
    if (len == 16'd0) begin
      return TIMER_BITS'(1);
    end else if (ext > tmax) begin
      return {TIMER_BITS{1'b1}};
    end
    return TIMER_BITS'(ext);
  endfunction

  always_comb begin : p_next
    logic [TIMER_BITS-1:0] tl_dec;
    logic [1:0]            n_seg;
    logic [3:0]            n_sym;
    logic                  n_sync;
    logic [3:0]            n_frame;
    logic                  finish;
    seg_t                  ld;
    active_nxt = active_r;
    frame_nxt  = frame_r;
    sym_nxt    = sym_r;
    seg_nxt    = seg_r;
    sync_nxt   = sync_r;
    tl_nxt     = tl_r;
    pat_nxt    = pat_r;
    level_nxt  = level_r;
    res        = '0;
    tl_dec     = (tl_r != '0) ? tl_r - TIMER_BITS'(1) : '0;
    n_seg      = seg_r;
    n_sym      = sym_r;
    n_sync     = sync_r;
    n_frame    = frame_r;
    finish     = 1'b0;
    ld         = '0;
    if (fire) begin
      if (req_type) begin
        res.busy_res = 1'b1;
        if (active_r) begin
          res.rejected = 1'b1;
        end else begin
          pat_nxt    = build_pattern(house_code, switch_number, power_on);
          active_nxt = 1'b1;
          frame_nxt  = '0;
          sym_nxt    = '0;
          seg_nxt    = '0;
          sync_nxt   = 1'b0;
          ld         = load_seg(1'b0, 2'd0, 4'd0, pat_nxt, cfg);
          level_nxt  = ld.level;
          tl_nxt     = clamp_len(ld.len);
        end
      end else if (active_r) begin
        res.busy_res  = 1'b1;
        res.line_high = level_r;
        tl_nxt        = tl_dec;
        if (tl_dec == '0) begin
          // Advance to the next segment, symbol, sync or frame.
          if (!sync_r) begin
            if (seg_r != 2'd3) begin
              n_seg = seg_r + 2'd1;
            end else begin
              n_seg = 2'd0;
              if (sym_r < 4'(Symbols - 1)) begin
                n_sym = sym_r + 4'd1;
              end else begin
                n_sync = 1'b1;
              end
            end
          end else if (seg_r == 2'd0) begin
            n_seg = 2'd1;
          end else begin
            n_frame = frame_r + 4'd1;
            if (n_frame >= cfg.repeat_count) begin
              finish = 1'b1;
            end else begin
              n_sync = 1'b0;
              n_sym  = '0;
              n_seg  = '0;
            end
          end
          if (finish) begin
            res.done_res = 1'b1;
            active_nxt   = 1'b0;
            sync_nxt     = 1'b0;
            frame_nxt    = '0;
            sym_nxt      = '0;
            seg_nxt      = '0;
            tl_nxt       = '0;
            level_nxt    = 1'b0;
          end else begin
            ld        = load_seg(n_sync, n_seg, n_sym, pat_r, cfg);
            frame_nxt = n_frame;
            sym_nxt   = n_sym;
            seg_nxt   = n_seg;
            sync_nxt  = n_sync;
            level_nxt = ld.level;
            tl_nxt    = clamp_len(ld.len);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      frame_r  <= '0;
      sym_r    <= '0;
      seg_r    <= '0;
      sync_r   <= 1'b0;
      tl_r     <= '0;
      pat_r    <= '0;
      level_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      frame_r  <= frame_nxt;
      sym_r    <= sym_nxt;
      seg_r    <= seg_nxt;
      sync_r   <= sync_nxt;
      tl_r     <= tl_nxt;
      pat_r    <= pat_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

/* rtl/ook_remote_switch_encoder.sv */
// One transaction is taken every clock cycle while in_stall is low; each is either a
// one-microsecond tick or a start command, and each gives exactly one result transaction.
// It passes the input register, then the result register; the sequencer state moves as a
// transaction leaves the input register, so a stalled output holds the state still. The
// frame is twelve tristate symbols of four timed segments each, a sync pulse and a low
// gap, sent repeat_count times (at least once); lengths use a TIMER_BITS-wide down-counter.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and read live.
// Depends on orse_pkg and orse_seq.
module ook_remote_switch_encoder #(
  parameter int unsigned TIMER_BITS = orse_pkg::TimerBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_house_code,
  input  logic [3:0]  in_switch_number,
  input  logic        in_power_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_line_high,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_rejected,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import orse_pkg::*;

  cfg_t       cfg_r;
  logic       a_valid_r;
  logic       a_req_r;
  logic [7:0] a_house_r;
  logic [3:0] a_sw_r;
  logic       a_pwr_r;
  logic       b_valid_r;
  res_t       b_res_r;
  res_t       res;
  logic       b_ready;
  logic       a_ready;
  logic       fire;

  assign b_ready  = !b_valid_r || !out_stall;
  assign a_ready  = !a_valid_r || b_ready;
  assign fire     = a_valid_r && b_ready;
  assign in_stall = !a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_pulse_us <= ShortPulseRst;
      cfg_r.long_pulse_us  <= LongPulseRst;
      cfg_r.sync_gap_us    <= SyncGapRst;
      cfg_r.repeat_count   <= RepeatCountRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SHORT_PULSE:  cfg_r.short_pulse_us <= cfg_wdata[11:0];
        REG_LONG_PULSE:   cfg_r.long_pulse_us  <= cfg_wdata[11:0];
        REG_SYNC_GAP:     cfg_r.sync_gap_us    <= cfg_wdata;
        REG_REPEAT_COUNT: cfg_r.repeat_count   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_req_r   <= in_req_type;
      a_house_r <= in_house_code;
      a_sw_r    <= in_switch_number;
      a_pwr_r   <= in_power_on;
    end
  end

  orse_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .req_type      (a_req_r),
    .house_code    (a_house_r),
    .switch_number (a_sw_r),
    .power_on      (a_pwr_r),
    .cfg           (cfg_r),
    .res           (res)
  );

  // Result register: hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_res_r <= res;
    end
  end

  assign out_valid     = b_valid_r;
  assign out_line_high = b_res_r.line_high;
  assign out_busy_res  = b_res_r.busy_res;
  assign out_done_res  = b_res_r.done_res;
  assign out_rejected  = b_res_r.rejected;

endmodule

/* rtl/orse_checker.sv */
// Port-level checks for the remote switch encoder, bound to the top level.
// Depends on ook_remote_switch_encoder's ports only.
module orse_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_line_high,
  input logic out_busy_res,
  input logic out_done_res,
  input logic out_rejected
);

  a_reset_clears_out : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_done_is_idle_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_busy_res && !out_line_high && !out_rejected)
    else $error("done transaction not busy or line high");

  a_reject_shape : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res && !out_line_high)
    else $error("rejected transaction malformed");

  a_idle_all_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> !out_line_high && !out_done_res && !out_rejected)
    else $error("idle transaction carries activity");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_high) && $stable(out_busy_res)
      && $stable(out_done_res) && $stable(out_rejected))
    else $error("stalled result changed");

endmodule

bind ook_remote_switch_encoder orse_checker u_orse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_line_high (out_line_high),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_rejected  (out_rejected)
);
